@@ hdl/parat_pkg.sv @@
// ----------------------------------------------------------------------------
// parat_pkg
// Shared types and constants of the path-prefix access rule table.
// ----------------------------------------------------------------------------
package parat_pkg;

	localparam int RULES        = 16;
	localparam int PREFIX       = 64;
	localparam int ACCESS_WIDTH = 16;

	localparam int RIDX_W = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int CNT_W  = $clog2(RULES + 1);
	localparam int POS_W  = $clog2(PREFIX + 1);
	localparam int LEN_W  = $clog2(PREFIX);
	localparam int TADR_W = $clog2(RULES * PREFIX);

	localparam logic [7:0] SLASH = 8'h2F;

	localparam logic [1:0] OP_RULE  = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_SEAL  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DENIED  = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	localparam logic [1:0] MS_PENDING = 2'd0;
	localparam logic [1:0] MS_FAILED  = 2'd1;
	localparam logic [1:0] MS_MATCHED = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  ch;
		logic        last;
		logic [15:0] access_bits;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] rules_in_use;
	} out_word_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [1:0]        op;
		logic [7:0]        ch;
		logic              last;
		logic [15:0]       bits;
		logic [POS_W-1:0]  pos;
	} cmd_t;

endpackage

@@ hdl/parat_ram.sv @@
// ----------------------------------------------------------------------------
// parat_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module parat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/parat_front.sv @@
// ----------------------------------------------------------------------------
// parat_front
// Accepts input words, tracks the character position and forwards
// classified words into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module parat_front import parat_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_data,
	output logic     q_valid,
	input  logic     q_ready,
	output cmd_t     q_data
);

	cmd_t             buf_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic [POS_W-1:0] pos_q;
	logic             sealed_q;
	cmd_t             cmd;
	logic             push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = buf_q[rp_q];
	assign pop      = q_valid && q_ready;

	// classify
	always_comb begin
		cmd.op   = in_data.op;
		cmd.ch   = in_data.ch;
		cmd.last = in_data.last;
		cmd.bits = in_data.access_bits[ACCESS_WIDTH-1:0];
		cmd.pos  = pos_q;
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= cmd;
		end
	end

	// position counter, seal shadow and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= 1'b0;
			rp_q     <= 1'b0;
			cnt_q    <= 2'd0;
			pos_q    <= '0;
			sealed_q <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
				if (in_data.op == OP_SEAL) begin
					// a repeated seal changes nothing
					if (!sealed_q) begin
						sealed_q <= 1'b1;
						pos_q    <= '0;
					end
				end else if (in_data.op == OP_RULE || in_data.op == OP_QUERY) begin
					if (in_data.last) begin
						pos_q <= '0;
					end else if (pos_q != POS_W'(PREFIX)) begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ hdl/parat_back.sv @@
// ----------------------------------------------------------------------------
// parat_back
// Executes rule, query and seal words. A query character walks the stored
// rules one per cycle through the text RAM and updates each match state.
// ----------------------------------------------------------------------------
module parat_back import parat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] allowed_q,
	input  logic        q_valid,
	output logic        q_ready,
	input  cmd_t        q_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_CHECK = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [CNT_W-1:0]  count_q;
	logic              sealed_q;
	logic [1:0]        ms_q [RULES];
	logic [LEN_W-1:0]  len_q [RULES];
	logic [ACCESS_WIDTH-1:0] grant_q [RULES];
	logic [RIDX_W-1:0] idx_q;
	logic [RIDX_W-1:0] idx_d1_q;
	logic              vld_d1_q;
	logic              out_valid_q;
	out_word_t         res_q;
	out_word_t         out_q;

	logic              t_we;
	logic [TADR_W-1:0] t_waddr, t_raddr;
	logic [7:0]        t_rdata;
	logic              take;
	logic              out_free;
	logic [POS_W-1:0]  pend;
	logic              found;
	logic [RIDX_W-1:0] hit;
	logic [ACCESS_WIDTH-1:0] amask;

	assign amask    = allowed_q[ACCESS_WIDTH-1:0];
	assign out_free = !out_valid_q || out_ready;
	assign q_ready  = (state_q == S_IDLE);
	assign take     = q_valid && q_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// rule text write on accepted rule characters
	always_comb begin
		t_we    = take && q_data.op == OP_RULE && count_q < CNT_W'(RULES) &&
			q_data.pos < POS_W'(PREFIX - 1);
		t_waddr = TADR_W'(count_q) * TADR_W'(PREFIX) + TADR_W'(q_data.pos);
		t_raddr = TADR_W'(idx_q) * TADR_W'(PREFIX) + TADR_W'(cmd_q.pos);
	end

	parat_ram #(.WIDTH(8), .DEPTH(RULES * PREFIX)) u_text (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (q_data.ch),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	// first matched rule
	always_comb begin
		found = 1'b0;
		hit   = '0;
		for (int i = RULES - 1; i >= 0; i--) begin
			if (CNT_W'(i) < count_q && ms_q[i] == MS_MATCHED) begin
				found = 1'b1;
				hit   = RIDX_W'(i);
			end
		end
	end

	assign pend = cmd_q.pos + ((cmd_q.pos != POS_W'(PREFIX)) ? 1'b1 : 1'b0);

	// rule metadata
	always_ff @(posedge clk) begin
		if (take && q_data.op == OP_RULE && q_data.last && !sealed_q &&
				count_q < CNT_W'(RULES) && (q_data.bits & ~amask) == '0) begin
			len_q[count_q[RIDX_W-1:0]] <= (q_data.pos < POS_W'(PREFIX - 1)) ?
				LEN_W'(q_data.pos + 1'b1) : LEN_W'(PREFIX - 1);
			grant_q[count_q[RIDX_W-1:0]] <= q_data.bits;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			count_q     <= '0;
			sealed_q    <= 1'b0;
			idx_q       <= '0;
			idx_d1_q    <= '0;
			vld_d1_q    <= 1'b0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
			out_q       <= '0;
			for (int i = 0; i < RULES; i++) ms_q[i] <= MS_PENDING;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						cmd_q <= q_data;
						if (q_data.op == OP_QUERY) begin
							if (q_data.pos == '0) begin
								for (int i = 0; i < RULES; i++) ms_q[i] <= MS_PENDING;
							end
							idx_q    <= '0;
							vld_d1_q <= 1'b0;
							state_q  <= S_SCAN;
						end else if (q_data.op == OP_RULE && !q_data.last) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_FIN;
							res_q.rules_in_use <= 5'(count_q);
							if (q_data.op == OP_RULE) begin
								if (sealed_q) res_q.status <= ST_INVALID;
								else if (count_q >= CNT_W'(RULES)) res_q.status <= ST_FULL;
								else if ((q_data.bits & ~amask) != '0)
									res_q.status <= ST_INVALID;
								else begin
									res_q.status <= ST_OK;
									count_q <= count_q + 1'b1;
									res_q.rules_in_use <= 5'(count_q + 1'b1);
								end
							end else if (q_data.op == OP_SEAL) begin
								res_q.status <= sealed_q ? ST_INVALID : ST_OK;
								sealed_q <= 1'b1;
							end else begin
								res_q.status <= ST_INVALID;
							end
						end
					end
				end
				S_SCAN: begin
					// issue read for idx_q, evaluate the rule read last cycle
					if (vld_d1_q && ms_q[idx_d1_q] == MS_PENDING) begin
						if (cmd_q.pos < POS_W'(len_q[idx_d1_q])) begin
							if (cmd_q.ch != t_rdata) ms_q[idx_d1_q] <= MS_FAILED;
							else if (len_q[idx_d1_q] == LEN_W'(1))
								ms_q[idx_d1_q] <= MS_MATCHED;
						end else if (cmd_q.pos == POS_W'(len_q[idx_d1_q])) begin
							ms_q[idx_d1_q] <= (cmd_q.ch == SLASH) ? MS_MATCHED : MS_FAILED;
						end else begin
							ms_q[idx_d1_q] <= MS_FAILED;
						end
					end
					idx_d1_q <= idx_q;
					if (vld_d1_q && (CNT_W'(idx_d1_q) + 1'b1 >= count_q)) begin
						vld_d1_q <= 1'b0;
						state_q  <= cmd_q.last ? S_CHECK : S_IDLE;
					end else if (CNT_W'(idx_q) >= count_q) begin
						vld_d1_q <= 1'b0;
						state_q  <= cmd_q.last ? S_CHECK : S_IDLE;
					end else begin
						vld_d1_q <= 1'b1;
						if (CNT_W'(idx_q) + 1'b1 < count_q) idx_q <= idx_q + 1'b1;
					end
				end
				S_CHECK: begin
					// resolve still-pending rules at path end
					for (int i = 0; i < RULES; i++) begin
						if (CNT_W'(i) < count_q && ms_q[i] == MS_PENDING) begin
							ms_q[i] <= (POS_W'(len_q[i]) == pend) ? MS_MATCHED : MS_FAILED;
						end
					end
					state_q <= S_FIN;
					res_q.rules_in_use <= 5'(count_q);
					res_q.status <= ST_OK;
				end
				S_FIN: begin
					// load the result word once the output register is free
					if (out_free) begin
						out_q.rules_in_use <= res_q.rules_in_use;
						if (cmd_q.op == OP_QUERY && sealed_q) begin
							out_q.status <= (found && (cmd_q.bits & ~grant_q[hit]) == '0) ?
								ST_OK : ST_DENIED;
						end else begin
							out_q.status <= res_q.status;
						end
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/path_prefix_access_rule_table_core.sv @@
// ----------------------------------------------------------------------------
// path_prefix_access_rule_table_core
// Path-prefix access rule table: front queue plus rule-scan back end.
//
//   channel | signals                     | word
//   in      | in_valid, in_ready, in_data | in_word_t
//   out     | out_valid,out_ready,out_data| out_word_t
//   cfg     | cfg_we, cfg_wdata           | allowed access set
//
// A query character holds the back end while it walks the stored rules one
// per cycle through the text RAM read port; a final query character adds
// the path-end check and the result load. Rule characters that end the path,
// seal words and unused words pass through the result load; others do not.
// Reset clears counters, seal and match states; stored rule text needs no
// clear. A two-word queue lets the front keep accepting while the back end
// scans or the result waits.
// ----------------------------------------------------------------------------
module path_prefix_access_rule_table_core import parat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] allowed_q;
	logic        q_valid, q_ready;
	cmd_t        q_data;

	// hold configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allowed_q <= 16'hFFFF;
		end else if (cfg_we) begin
			allowed_q <= cfg_wdata;
		end
	end

	parat_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	parat_back u_back (
		.clk(clk), .arst_n(arst_n), .allowed_q(allowed_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the path-prefix access rule table core. Rule and
// query paths are streamed in one character per word. A built-in predictor
// tracks the rule table, the seal and the per-rule match states, and every
// result word is compared with the oldest predicted one. Both channels idle
// and stall at random, and the allowed access set is rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
	import parat_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_SPARE   = 2'd3;
	localparam int         WATCHDOG   = 20000;
	localparam int         SETTLE     = RULES + 24;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	// table shadow
	logic [7:0]       tbl_text [RULES][PREFIX];
	int unsigned      tbl_len [RULES];
	logic [15:0]      tbl_grant [RULES];
	int unsigned      tbl_count;
	bit               tbl_sealed;
	int unsigned      tbl_pos;
	logic [1:0]       tbl_state [RULES];
	logic [15:0]      allowed_set;

	out_word_t verdict_q [$];
	int        words_sent;
	int        fail_count;
	int        burst_left;
	int        idle_cycles;
	int        ready_mode;
	int        mode_left;
	int        stall_left;

	path_prefix_access_rule_table_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic out_word_t make_verdict(logic [1:0] st);
		out_word_t v;
		v.status       = st;
		v.rules_in_use = tbl_count[4:0];
		return v;
	endfunction

	// advance the shadow table by one accepted word, queue any verdict
	task automatic track_word(in_word_t w);
		int unsigned p;
		int unsigned plen;
		bit          found;
		logic [1:0]  st;
		case (w.op)
			OP_RULE: begin
				if (tbl_count < RULES && tbl_pos < PREFIX - 1)
					tbl_text[tbl_count][tbl_pos] = w.ch;
				if (tbl_pos < PREFIX)
					tbl_pos++;
				if (w.last) begin
					plen = (tbl_pos < PREFIX - 1) ? tbl_pos : PREFIX - 1;
					tbl_pos = 0;
					if (tbl_sealed)
						st = ST_INVALID;
					else if (tbl_count >= RULES)
						st = ST_FULL;
					else if ((w.access_bits & ~allowed_set) != 0)
						st = ST_INVALID;
					else begin
						tbl_len[tbl_count]   = plen;
						tbl_grant[tbl_count] = w.access_bits;
						tbl_count++;
						st = ST_OK;
					end
					verdict_q.push_back(make_verdict(st));
				end
			end
			OP_QUERY: begin
				p = tbl_pos;
				if (p == 0)
					foreach (tbl_state[i]) tbl_state[i] = MS_PENDING;
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_state[i] != MS_PENDING)
						continue;
					if (p < tbl_len[i]) begin
						if (w.ch != tbl_text[i][p])
							tbl_state[i] = MS_FAILED;
						else if (tbl_len[i] == 1)
							tbl_state[i] = MS_MATCHED;
					end else if (p == tbl_len[i])
						tbl_state[i] = (w.ch == SLASH) ? MS_MATCHED : MS_FAILED;
					else
						tbl_state[i] = MS_FAILED;
				end
				if (p < PREFIX)
					p++;
				tbl_pos = p;
				if (w.last) begin
					tbl_pos = 0;
					for (int i = 0; i < tbl_count; i++)
						if (tbl_state[i] == MS_PENDING)
							tbl_state[i] = (tbl_len[i] == p) ? MS_MATCHED : MS_FAILED;
					st    = tbl_sealed ? ST_DENIED : ST_OK;
					found = 1'b0;
					if (tbl_sealed)
						for (int i = 0; i < tbl_count && !found; i++)
							if (tbl_state[i] == MS_MATCHED) begin
								found = 1'b1;
								st = ((w.access_bits & ~tbl_grant[i]) != 0) ? ST_DENIED : ST_OK;
							end
					verdict_q.push_back(make_verdict(st));
				end
			end
			OP_SEAL: begin
				if (tbl_sealed)
					st = ST_INVALID;
				else begin
					tbl_sealed = 1'b1;
					tbl_pos    = 0;
					st         = ST_OK;
				end
				verdict_q.push_back(make_verdict(st));
			end
			default: verdict_q.push_back(make_verdict(ST_INVALID));
		endcase
	endtask

	// drive one word in a burst; entered and left at a falling edge
	task automatic send_word(logic [1:0] op, logic [7:0] ch, logic last, logic [15:0] bits);
		in_word_t w;
		w.op = op;
		w.ch = ch;
		w.last = last;
		w.access_bits = bits;
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 20);
		end
		in_valid = 1'b1;
		in_data  = w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		track_word(w);
		words_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_path(logic [1:0] op, logic [7:0] path [$], logic [15:0] bits);
		foreach (path[i])
			send_word(op, path[i], i == path.size() - 1, bits);
	endtask

	// hold until every verdict is in and the back end has settled
	task automatic drain();
		in_valid = 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_allowed(logic [15:0] value);
		drain();
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		allowed_set = value;
	endtask

	function automatic logic [7:0] path_char();
		case ($urandom_range(0, 9))
			0, 1, 2: return SLASH;
			3, 4:    return "a";
			5, 6:    return "b";
			7:       return "c";
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic random_path(output logic [7:0] path [$]);
		int n;
		path = {};
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 6);
		repeat (n) path.push_back(path_char());
	endtask

	// build a query mostly from a stored rule so that matches happen often
	task automatic random_query(output logic [7:0] path [$]);
		int r;
		int k;
		path = {};
		k = $urandom_range(0, 9);
		if (tbl_count == 0 || k < 2) begin
			random_path(path);
			return;
		end
		r = $urandom_range(0, tbl_count - 1);
		for (int j = 0; j < tbl_len[r]; j++)
			path.push_back(tbl_text[r][j]);
		if (k == 2 && path.size() > 1)
			void'(path.pop_back());
		else if (k >= 6) begin
			path.push_back((k == 9) ? path_char() : SLASH);
			repeat ($urandom_range(0, 4)) path.push_back(path_char());
		end
		if ($urandom_range(0, 29) == 0)
			while (path.size() < 70) path.push_back(path_char());
	endtask

	function automatic logic [15:0] random_bits();
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'(1 << $urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_mask_limits();
		write_allowed(16'h0000);
		send_path(OP_RULE, '{"/", "u"}, 16'h0000);
		send_path(OP_RULE, '{"/", "v"}, 16'h0001);
		write_allowed(16'hFFFF);
		send_path(OP_RULE, '{"/", "v"}, 16'hFFFF);
		send_path(OP_RULE, '{"/", "w"}, 16'h8000);
	endtask

	task automatic test_long_rule();
		logic [7:0] p [$];
		repeat (70) p.push_back(8'hFF);
		send_path(OP_RULE, p, 16'h00F0);
		send_path(OP_RULE, '{"a"}, 16'h0F0F);
	endtask

	task automatic test_open_queries();
		logic [7:0] p [$];
		repeat (80) p.push_back(8'h01);
		send_path(OP_QUERY, p, 16'hFFFF);
		send_path(OP_QUERY, '{"/", "v", "/", "x"}, 16'hFFFF);
		send_word(OP_SPARE, 8'h80, 1'b1, 16'h5555);
	endtask

	// add rules, mixed with queries, until the table overflows, with masks that step outside the set
	task automatic test_random_rules();
		logic [7:0] p [$];
		int phase_end;
		for (int ph = 0; ph < 3; ph++) begin
			write_allowed(ph == 0 ? 16'h00FF : (ph == 1 ? 16'($urandom) : 16'hFFFF));
			phase_end = words_sent + 120;
			while (words_sent < phase_end) begin
				random_path(p);
				if ($urandom_range(0, 2) == 0)
					send_path(OP_QUERY, p, random_bits());
				else
					send_path(OP_RULE, p, random_bits() & ($urandom_range(0, 1) ? allowed_set
					                                                           : 16'hFFFF));
				if ($urandom_range(0, 30) == 0)
					send_word(OP_SPARE, path_char(), 1'($urandom_range(0, 1)), random_bits());
			end
		end
		while (tbl_count < RULES)
			send_path(OP_RULE, '{"/", "z"}, 16'h0000);
		send_path(OP_RULE, '{"/", "q"}, 16'h0000);
	endtask

	// a seal also drops a partly received path
	task automatic test_seal();
		send_word(OP_QUERY, "/", 1'b0, 16'h0000);
		send_word(OP_QUERY, "a", 1'b0, 16'h0000);
		send_word(OP_SEAL, 8'h00, 1'b0, 16'h0000);
		send_word(OP_SEAL, 8'hFF, 1'b1, 16'hFFFF);
		send_path(OP_RULE, '{"/", "s"}, 16'h0000);
		send_word(OP_SPARE, 8'h2F, 1'b0, 16'h0000);
		send_path(OP_QUERY, '{"/", "v"}, 16'h0001);
		send_path(OP_QUERY, '{"a"}, 16'h0F0F);
		send_path(OP_QUERY, '{"a", "/"}, 16'hF0F0);
		send_path(OP_QUERY, '{"k"}, 16'h0000);
	endtask

	task automatic test_random_queries();
		logic [7:0] p [$];
		int phase_end;
		for (int ph = 0; ph < 4; ph++) begin
			write_allowed(ph == 0 ? 16'h0000 : 16'($urandom));
			phase_end = words_sent + 240;
			while (words_sent < phase_end) begin
				random_query(p);
				case ($urandom_range(0, 19))
					0:       send_path(OP_RULE, p, random_bits());
					1:       send_word(OP_SEAL, path_char(), 1'b1, random_bits());
					2:       send_word(OP_SPARE, path_char(), 1'b0, random_bits());
					default: send_path(OP_QUERY, p, random_bits());
				endcase
			end
		end
	endtask

	// receiver: switch between free-running, random and long-stall patterns
	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			mode_left  = $urandom_range(100, 400);
		end
		mode_left--;
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (ready_mode == 1)
			out_ready <= 1'($urandom_range(0, 1));
		else if (ready_mode == 2 && $urandom_range(0, 15) == 0) begin
			stall_left = $urandom_range(5, 30);
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	// compare each result word with the oldest prediction
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				$error("unexpected result word status=%0d rules_in_use=%0d",
				       out_data.status, out_data.rules_in_use);
				fail_count++;
			end else begin
				want = verdict_q.pop_front();
				if (out_data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_data.status);
					fail_count++;
				end
				if (out_data.rules_in_use !== want.rules_in_use) begin
					$error("rules_in_use: expected %0d, got %0d",
					       want.rules_in_use, out_data.rules_in_use);
					fail_count++;
				end
			end
		end
	end

	// end the run if neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("path_prefix_access_rule_table_core: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		words_sent  = 0;
		fail_count  = 0;
		burst_left  = 0;
		idle_cycles = 0;
		ready_mode  = 0;
		mode_left   = 0;
		stall_left  = 0;
		tbl_count   = 0;
		tbl_sealed  = 1'b0;
		tbl_pos     = 0;
		allowed_set = 16'hFFFF;
		foreach (tbl_state[i]) tbl_state[i] = MS_PENDING;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_mask_limits();
		test_long_rule();
		test_open_queries();
		test_random_rules();
		test_seal();
		test_random_queries();
		drain();
		if (fail_count == 0)
			$display("path_prefix_access_rule_table_core: match");
		else
			$display("path_prefix_access_rule_table_core: mismatch");
		$finish;
	end

endmodule
